[rtl/core/lbt_pkg.sv]
// Bit-plane transposer package: command codes, queue entry type, constants.
// Used by the front, queue, back and top-level modules.
package lbt_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int          PlaneCount  = 24;
  localparam logic [4:0]  PlaneMsb    = 5'd23;
  localparam logic [7:0]  ColumnReset = 8'd1;
  // floor(x / 24) = (x * 2731) >> 16 for x below 6120
  localparam logic [11:0] RecipDiv24  = 12'd2731;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_REJECT
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  col;
    logic [3:0]  row;
    logic [23:0] grb;
    logic [4:0]  plane;
  } op_t;

endpackage

[rtl/core/lbt_front.sv]
// Front end: column count register, range checks, index split and colour reorder.
// Depends on lbt_pkg; feeds classified requests to lbt_queue.
module lbt_front import lbt_pkg::*; #(
  parameter int STRIP_COUNT = 16,
  parameter int MAX_COLUMNS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        cmd_i,
  input  logic [3:0]  pixel_row_i,
  input  logic [7:0]  pixel_column_i,
  input  logic [23:0] pixel_rgb_i,
  input  logic [12:0] word_index_i,
  output op_t         op_o
);

  localparam logic [7:0] MaxCols  = 8'(MAX_COLUMNS);
  localparam logic [4:0] StripLim = 5'(STRIP_COUNT);

  logic [7:0]  count_q, count_d;
  logic [7:0]  eff_cols;
  logic [12:0] idx_limit;
  logic [24:0] prod;
  logic [7:0]  quot;
  logic [12:0] quot_x24;
  logic [12:0] rem;

  always_comb begin
    count_d = count_q;
    if (cfg_wr_i) begin
      count_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ColumnReset;
    end else begin
      count_q <= count_d;
    end
  end

  assign eff_cols  = (count_q > MaxCols) ? MaxCols : count_q;
  assign idx_limit = ({5'd0, eff_cols} << 4) + ({5'd0, eff_cols} << 3);

  assign prod     = 25'(word_index_i) * 25'(RecipDiv24);
  assign quot     = prod[23:16];
  assign quot_x24 = ({5'd0, quot} << 4) + ({5'd0, quot} << 3);
  assign rem      = word_index_i - quot_x24;

  always_comb begin
    op_o       = '0;
    op_o.kind  = OP_REJECT;
    op_o.row   = pixel_row_i;
    op_o.grb   = {pixel_rgb_i[15:8], pixel_rgb_i[23:16], pixel_rgb_i[7:0]};
    case (cmd_i)
      CMD_WRITE: begin
        op_o.col = pixel_column_i;
        if ((pixel_column_i < eff_cols) && ({1'b0, pixel_row_i} < StripLim)) begin
          op_o.kind = OP_WRITE;
        end
      end
      CMD_READ: begin
        op_o.col   = quot;
        op_o.plane = rem[4:0];
        if (word_index_i < idx_limit) begin
          op_o.kind = OP_READ;
        end
      end
      default: begin
        op_o.kind = OP_REJECT;
      end
    endcase
  end

endmodule

[rtl/core/lbt_queue.sv]
// Two-entry request queue between front and back ends.
// Depends on lbt_pkg for the entry type.
module lbt_queue import lbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  input  logic pop_i,
  output op_t  data_o,
  output logic full_o,
  output logic empty_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);

endmodule

[rtl/core/lbt_back.sv]
// Back end: per-strip colour memories, start-up clear pass, read and result stage.
// Depends on lbt_pkg; drains lbt_queue one request per cycle once the clear pass is over.
module lbt_back import lbt_pkg::*; #(
  parameter int STRIP_COUNT = 16,
  parameter int MAX_COLUMNS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  op_t         op_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        done_o,
  output logic [15:0] read_word_o,
  output logic        status_o
);

  localparam int             ColW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [ColW-1:0] MaxIdx = ColW'(MAX_COLUMNS - 1);

  logic                               clearing_q, clearing_d;
  logic [ColW-1:0]                    clr_q, clr_d;
  logic                               done_q, status_q, is_read_q;
  logic [4:0]                         plane_q;
  logic [STRIP_COUNT-1:0][PlaneCount-1:0] rd_q;
  logic [ColW-1:0]                    addr;
  logic [4:0]                         bit_sel;

  assign pop_o = valid_i && !clearing_q;
  assign addr  = op_i.col[ColW-1:0];

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + ColW'(1);
      if (clr_q == MaxIdx) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      done_q     <= 1'b0;
      status_q   <= 1'b0;
      is_read_q  <= 1'b0;
      plane_q    <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
      done_q     <= pop_o;
      status_q   <= pop_o && (op_i.kind == OP_REJECT);
      is_read_q  <= pop_o && (op_i.kind == OP_READ);
      plane_q    <= op_i.plane;
    end
  end

  for (genvar lane = 0; lane < STRIP_COUNT; lane++) begin : g_lane
    logic [PlaneCount-1:0] mem [MAX_COLUMNS];

    always_ff @(posedge clk_i) begin
      if (clearing_q) begin
        mem[clr_q] <= '0;
      end else if (pop_o && (op_i.kind == OP_WRITE) && (op_i.row == 4'(lane))) begin
        mem[addr] <= op_i.grb;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pop_o) begin
        rd_q[lane] <= mem[addr];
      end
    end
  end

  assign bit_sel = PlaneMsb - plane_q;

  for (genvar b = 0; b < 16; b++) begin : g_out
    if (b < STRIP_COUNT) begin : g_used
      assign read_word_o[b] = is_read_q & rd_q[b][bit_sel];
    end else begin : g_unused
      assign read_word_o[b] = 1'b0;
    end
  end

  assign clearing_o = clearing_q;
  assign done_o     = done_q;
  assign status_o   = status_q;

endmodule

[rtl/core/led_pixel_bitplane_transposer.sv]
// Top level of the LED bit-plane transposer: ports, front end, queue, back end.
// Depends on lbt_pkg, lbt_front, lbt_queue and lbt_back.
//
// Takes one request per cycle while busy is low; each request gives exactly one
// result, flagged by done_o, registered as the back end pops it off the queue.
// Results cannot be held off by the receiver, so the back end drains its queue
// every cycle once the clear pass is over; busy rises when that two-entry queue
// is full or while the clear pass runs, which after reset walks all MAX_COLUMNS
// columns one per cycle with busy high; column count writes are taken anyway.
module led_pixel_bitplane_transposer import lbt_pkg::*; #(
  parameter int STRIP_COUNT = 16,
  parameter int MAX_COLUMNS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [3:0]  pixel_row_i,
  input  logic [7:0]  pixel_column_i,
  input  logic [23:0] pixel_rgb_i,
  input  logic [12:0] word_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic [15:0] read_word_o,
  output logic        status_o
);

  op_t  front_op;
  op_t  queue_op;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic clearing;

  assign cfg_ready_o = 1'b1;
  assign busy        = full || clearing;
  assign push        = start && !busy;

  lbt_front #(
    .STRIP_COUNT(STRIP_COUNT),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_column_i(pixel_column_i),
    .pixel_rgb_i   (pixel_rgb_i),
    .word_index_i  (word_index_i),
    .op_o          (front_op)
  );

  lbt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_op),
    .pop_i  (pop),
    .data_o (queue_op),
    .full_o (full),
    .empty_o(empty)
  );

  lbt_back #(
    .STRIP_COUNT(STRIP_COUNT),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (!empty),
    .op_i       (queue_op),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .read_word_o(read_word_o),
    .status_o   (status_o)
  );

endmodule
